// ===== design/rtip_pkg.sv =====
package rtip_pkg;

  localparam int RING_COUNT   = 16;
  localparam int COLUMN_COUNT = 1800;

  localparam int RING_W  = 4;
  localparam int COL_W   = 11;
  localparam int RANGE_W = 18;
  localparam int COORD_W = 18;
  localparam int TRIG_W  = 16;
  localparam int MAG_W   = 17;
  localparam int RAW_W   = 12;
  localparam int OCT_W   = 8;

  // angles in units of 0.2 deg
  localparam int UNITS_TURN    = 1800;
  localparam int UNITS_QUARTER = 450;
  localparam int UNITS_EIGHTH  = 225;
  localparam int OCT_ENTRIES   = UNITS_EIGHTH + 1;
  localparam int ELEV_STEP     = 10;
  // elevation ring*10 - 75 and azimuth col + 1 - 900, both shifted by a full turn
  localparam int ELEV_OFFSET   = UNITS_TURN - 75;
  localparam int AZ_OFFSET     = UNITS_TURN - 899;

  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] PI_STEP = PI_Q60 / 900;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic [OCT_W-1:0] idx;
    logic             swap;
    quad_t            quad;
  } angle_sel_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } sincos_t;

  typedef struct packed {
    logic signed [RANGE_W-1:0] range;
    sincos_t                   elev;
    sincos_t                   azim;
  } rtip_word_t;

  typedef logic [OCT_ENTRIES-1:0][2*MAG_W-1:0] oct_rom_t;

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // taylor series for sin and cos over the first octant, q60 internally
  function automatic logic [2*MAG_W-1:0] oct_sincos(input int unsigned u);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        st;
    logic [63:0]        ct;
    logic signed [63:0] ss;
    logic signed [63:0] cs;
    logic [63:0]        sr;
    logic [63:0]        cr;
    logic [63:0]        s;
    logic [63:0]        c;
    x  = 64'(u) * PI_STEP;
    x2 = mul_q60(x, x);
    st = x;
    ct = ONE_Q60;
    ss = $signed(x);
    cs = $signed(ONE_Q60);
    ct = mul_q60(ct, x2) / 64'd2;   st = mul_q60(st, x2) / 64'd6;
    cs = cs - $signed(ct);          ss = ss - $signed(st);
    ct = mul_q60(ct, x2) / 64'd12;  st = mul_q60(st, x2) / 64'd20;
    cs = cs + $signed(ct);          ss = ss + $signed(st);
    ct = mul_q60(ct, x2) / 64'd30;  st = mul_q60(st, x2) / 64'd42;
    cs = cs - $signed(ct);          ss = ss - $signed(st);
    ct = mul_q60(ct, x2) / 64'd56;  st = mul_q60(st, x2) / 64'd72;
    cs = cs + $signed(ct);          ss = ss + $signed(st);
    ct = mul_q60(ct, x2) / 64'd90;  st = mul_q60(st, x2) / 64'd110;
    cs = cs - $signed(ct);          ss = ss - $signed(st);
    ct = mul_q60(ct, x2) / 64'd132; st = mul_q60(st, x2) / 64'd156;
    cs = cs + $signed(ct);          ss = ss + $signed(st);
    ct = mul_q60(ct, x2) / 64'd182; st = mul_q60(st, x2) / 64'd210;
    cs = cs - $signed(ct);          ss = ss - $signed(st);
    ct = mul_q60(ct, x2) / 64'd240; st = mul_q60(st, x2) / 64'd272;
    cs = cs + $signed(ct);          ss = ss + $signed(st);
    ct = mul_q60(ct, x2) / 64'd306; st = mul_q60(st, x2) / 64'd342;
    cs = cs - $signed(ct);          ss = ss - $signed(st);
    ct = mul_q60(ct, x2) / 64'd380; st = mul_q60(st, x2) / 64'd420;
    cs = cs + $signed(ct);          ss = ss + $signed(st);
    ct = mul_q60(ct, x2) / 64'd462; st = mul_q60(st, x2) / 64'd506;
    cs = cs - $signed(ct);          ss = ss - $signed(st);
    ct = mul_q60(ct, x2) / 64'd552; st = mul_q60(st, x2) / 64'd600;
    cs = cs + $signed(ct);          ss = ss + $signed(st);
    ct = mul_q60(ct, x2) / 64'd650; st = mul_q60(st, x2) / 64'd702;
    cs = cs - $signed(ct);          ss = ss - $signed(st);
    sr = (ss < 0) ? 64'd0 : 64'(ss);
    cr = (cs < 0) ? 64'd0 : 64'(cs);
    s  = (sr + 64'h0000_1000_0000_0000) >> 45;
    c  = (cr + 64'h0000_1000_0000_0000) >> 45;
    return {s[MAG_W-1:0], c[MAG_W-1:0]};
  endfunction

  function automatic oct_rom_t build_oct_rom();
    oct_rom_t rom;
    for (int unsigned u = 0; u < OCT_ENTRIES; u++) begin
      rom[u] = oct_sincos(u);
    end
    return rom;
  endfunction

  localparam oct_rom_t OCT_ROM = build_oct_rom();

  // raw angle below two turns -> octant entry, swap flag and quadrant
  function automatic angle_sel_t angle_select(input logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] m;
    logic [RAW_W-1:0] r;
    angle_sel_t       a;
    m = (raw >= RAW_W'(UNITS_TURN)) ? raw - RAW_W'(UNITS_TURN) : raw;
    priority if (m >= RAW_W'(3 * UNITS_QUARTER)) begin
      a.quad = QUAD_3;
      r = m - RAW_W'(3 * UNITS_QUARTER);
    end else if (m >= RAW_W'(2 * UNITS_QUARTER)) begin
      a.quad = QUAD_2;
      r = m - RAW_W'(2 * UNITS_QUARTER);
    end else if (m >= RAW_W'(UNITS_QUARTER)) begin
      a.quad = QUAD_1;
      r = m - RAW_W'(UNITS_QUARTER);
    end else begin
      a.quad = QUAD_0;
      r = m;
    end
    if (r <= RAW_W'(UNITS_EIGHTH)) begin
      a.idx  = r[OCT_W-1:0];
      a.swap = 1'b0;
    end else begin
      a.idx  = OCT_W'(RAW_W'(UNITS_QUARTER) - r);
      a.swap = 1'b1;
    end
    return a;
  endfunction

  function automatic logic signed [TRIG_W-1:0] sat_trig(input logic signed [MAG_W:0] v);
    return (v > (MAG_W+1)'(32767)) ? TRIG_W'(32767) : v[TRIG_W-1:0];
  endfunction

  function automatic sincos_t sincos_lookup(input angle_sel_t a);
    logic [MAG_W-1:0]        s0;
    logic [MAG_W-1:0]        c0;
    logic signed [MAG_W:0]   sp;
    logic signed [MAG_W:0]   cp;
    logic signed [MAG_W:0]   s1;
    logic signed [MAG_W:0]   c1;
    sincos_t                 res;
    if (a.swap) begin
      {c0, s0} = OCT_ROM[a.idx];
    end else begin
      {s0, c0} = OCT_ROM[a.idx];
    end
    sp = $signed({1'b0, s0});
    cp = $signed({1'b0, c0});
    unique case (a.quad)
      QUAD_0: begin s1 = sp;  c1 = cp;  end
      QUAD_1: begin s1 = cp;  c1 = -sp; end
      QUAD_2: begin s1 = -sp; c1 = -cp; end
      QUAD_3: begin s1 = -cp; c1 = sp;  end
      default: begin s1 = sp; c1 = cp; end
    endcase
    res.s = sat_trig(s1);
    res.c = sat_trig(c1);
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [COORD_W+1:0] v);
    logic signed [COORD_W-1:0] res;
    if (v > (COORD_W+2)'(131071)) begin
      res = COORD_W'(131071);
    end else if (v < -(COORD_W+2)'(131072)) begin
      res = COORD_W'(-131072);
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== design/range_image_to_point_xyz_core.sv =====
// range image pixel to cartesian point converter
// input: one pixel word (ring, azimuth_column, range_value) is taken at each
// rising edge where start is high and busy is low. the word is classified in
// the front section; pixels with a non-positive range, a ring at or above the
// ring count or a column at or above the column count produce no point.
// output: each point appears on point_x, point_y and point_z for exactly one
// cycle with strobe high, in the same fixed-point format as range_value.
// path: a kept pixel passes through two front stages, the queue and two
// multiply stages before its point is strobed out.
// throughput: one pixel per cycle. the back section always drains the queue,
// so busy only rises if the queue were full, and in steady streaming it stays
// low; the front never waits on the multiplier pipeline.
// the receiver cannot stall: points are not held, and none are lost.
// reset (rst, synchronous) empties the pipeline and the queue; pixels in
// flight are discarded and no strobe follows.
module range_image_to_point_xyz_core
  import rtip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [RING_W-1:0]         ring,
  input  logic [COL_W-1:0]          azimuth_column,
  input  logic signed [RANGE_W-1:0] range_value,
  output logic                      strobe,
  output logic signed [COORD_W-1:0] point_x,
  output logic signed [COORD_W-1:0] point_y,
  output logic signed [COORD_W-1:0] point_z
);

  logic       push;
  rtip_word_t push_word;
  rtip_word_t pop_word;
  logic       queue_full;
  logic       queue_empty;
  logic       pop;

  assign pop = !queue_empty;

  rtip_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .ring           (ring),
    .azimuth_column (azimuth_column),
    .range_value    (range_value),
    .queue_full     (queue_full),
    .busy           (busy),
    .push           (push),
    .push_word      (push_word)
  );

  rtip_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  rtip_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pop),
    .in_word  (pop_word),
    .strobe   (strobe),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z)
  );

endmodule

// ===== design/rtip_front.sv =====
module rtip_front
  import rtip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [RING_W-1:0]         ring,
  input  logic [COL_W-1:0]          azimuth_column,
  input  logic signed [RANGE_W-1:0] range_value,
  input  logic                      queue_full,
  output logic                      busy,
  output logic                      push,
  output rtip_word_t                push_word
);

  logic                      adv;
  logic                      keep;
  logic [RAW_W-1:0]          elev_raw;
  logic [RAW_W-1:0]          azim_raw;

  logic                      s1_valid;
  logic signed [RANGE_W-1:0] s1_range;
  angle_sel_t                s1_elev;
  angle_sel_t                s1_azim;

  logic                      s2_valid;
  rtip_word_t                s2_word;

  assign adv  = !(s2_valid && queue_full);
  assign busy = !adv;

  // pixels with no point are dropped here and never reach the queue
  assign keep = start && (range_value > 0)
             && ({1'b0, ring} < (RING_W+1)'(RING_COUNT))
             && (azimuth_column < COL_W'(COLUMN_COUNT));

  assign elev_raw = RAW_W'(ring) * RAW_W'(ELEV_STEP) + RAW_W'(ELEV_OFFSET);
  assign azim_raw = RAW_W'(azimuth_column) + RAW_W'(AZ_OFFSET);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= keep;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_range     <= range_value;
      s1_elev      <= angle_select(elev_raw);
      s1_azim      <= angle_select(azim_raw);
      s2_word.range <= s1_range;
      s2_word.elev  <= sincos_lookup(s1_elev);
      s2_word.azim  <= sincos_lookup(s1_azim);
    end
  end

  assign push      = s2_valid && !queue_full;
  assign push_word = s2_word;

endmodule

// ===== design/rtip_queue.sv =====
module rtip_queue
  import rtip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rtip_word_t push_word,
  input  logic       pop,
  output rtip_word_t pop_word,
  output logic       full,
  output logic       empty
);

  rtip_word_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a word");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

// ===== design/rtip_back.sv =====
module rtip_back
  import rtip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  rtip_word_t                in_word,
  output logic                      strobe,
  output logic signed [COORD_W-1:0] point_x,
  output logic signed [COORD_W-1:0] point_y,
  output logic signed [COORD_W-1:0] point_z
);

  localparam int PROD1_W = RANGE_W + TRIG_W;
  localparam int P_W     = RANGE_W + 1;
  localparam int PROD2_W = P_W + TRIG_W;

  logic signed [PROD1_W-1:0] prod_p;
  logic signed [PROD1_W-1:0] prod_z;
  logic signed [PROD2_W-1:0] prod_x;
  logic signed [PROD2_W-1:0] prod_y;

  logic                      a_valid;
  logic signed [P_W-1:0]     a_p;
  logic signed [P_W-1:0]     a_z;
  sincos_t                   a_azim;

  // round to nearest, halves up: add half an lsb then arithmetic shift
  assign prod_p = PROD1_W'(in_word.range * in_word.elev.c) + PROD1_W'(16384);
  assign prod_z = PROD1_W'(in_word.range * in_word.elev.s) + PROD1_W'(16384);
  assign prod_x = PROD2_W'(a_p * a_azim.c) + PROD2_W'(16384);
  assign prod_y = PROD2_W'(a_p * a_azim.s) + PROD2_W'(16384);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      a_valid <= in_valid;
      strobe  <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_p     <= prod_p[PROD1_W-1:15];
    a_z     <= prod_z[PROD1_W-1:15];
    a_azim  <= in_word.azim;
    point_x <= sat_coord(prod_x[PROD2_W-1:15]);
    point_y <= sat_coord(prod_y[PROD2_W-1:15]);
    point_z <= sat_coord((COORD_W+2)'(a_z));
  end

endmodule
